// ===== design/vfcm_pkg.sv =====
package vfcm_pkg;

	localparam int unsigned TALL = 128;
	localparam int unsigned FACES = 6;
	localparam int unsigned VERTS = 6;

	localparam logic [6:0] TOP_Y = 7'(TALL - 1);

	typedef logic [2:0] vfcm_face_t;

	localparam vfcm_face_t FACE_NEG_Y = 3'd4;
	localparam vfcm_face_t FACE_POS_Y = 3'd5;
	localparam logic [2:0] LAST_VTX = 3'd5;

	typedef struct packed {
		logic [3:0] pos_x;
		logic [6:0] pos_y;
		logic [3:0] pos_z;
		logic [7:0] kind;
		logic       solid_here;
		logic       clear_here;
		logic [5:0] near_active;
		logic [5:0] near_clear;
	} vfcm_in_t;

	typedef struct packed {
		logic [7:0] byte_pos;
		logic [7:0] byte_corner;
		logic [4:0] byte_z;
		logic [7:0] byte_kind;
		logic       layer;
		logic       last;
	} vfcm_out_t;

	typedef struct packed {
		logic [3:0] pos_x;
		logic [6:0] pos_y;
		logic [3:0] pos_z;
		logic [7:0] kind;
		logic       clear;
		logic [5:0] faces;
	} vfcm_job_t;

	typedef struct packed {
		logic      push;
		vfcm_job_t job;
	} vfcm_push_t;

	typedef struct packed {
		logic full;
		logic nonempty;
	} vfcm_qstat_t;

	// Each entry is {corner[1:0], dz, dy, dx}.
	localparam logic [4:0] FACE_VERTS [FACES][VERTS] = '{
		'{5'd0,  5'd12, 5'd18, 5'd18, 5'd12, 5'd30},
		'{5'd5,  5'd9,  5'd23, 5'd23, 5'd9,  5'd27},
		'{5'd1,  5'd8,  5'd19, 5'd19, 5'd8,  5'd26},
		'{5'd4,  5'd13, 5'd22, 5'd22, 5'd13, 5'd31},
		'{5'd5,  5'd12, 5'd17, 5'd17, 5'd12, 5'd24},
		'{5'd3,  5'd10, 5'd23, 5'd23, 5'd10, 5'd30}
	};

	localparam logic [1:0] FACE_CLASS [FACES] = '{2'd0, 2'd0, 2'd1, 2'd1, 2'd3, 2'd2};

endpackage

// ===== design/vfcm_front.sv =====
module vfcm_front (
	input  logic                  start,
	input  vfcm_pkg::vfcm_in_t    voxel,
	input  vfcm_pkg::vfcm_qstat_t qstat,
	output logic                  busy,
	output vfcm_pkg::vfcm_push_t  push
);
	import vfcm_pkg::*;

	logic [5:0] vis;

	always_comb begin
		vis = ~voxel.near_active | (voxel.near_clear & {6{~voxel.clear_here}});
		if (voxel.pos_y == 7'd0) begin
			vis[FACE_NEG_Y] = 1'b1;
		end
		if (voxel.pos_y >= TOP_Y) begin
			vis[FACE_POS_Y] = 1'b1;
		end
	end

	assign busy = qstat.full;

	always_comb begin
		push.push      = start && !qstat.full && voxel.solid_here && (vis != 6'd0);
		push.job.pos_x = voxel.pos_x;
		push.job.pos_y = voxel.pos_y;
		push.job.pos_z = voxel.pos_z;
		push.job.kind  = voxel.kind;
		push.job.clear = voxel.clear_here;
		push.job.faces = vis;
	end

endmodule

// ===== design/vfcm_queue.sv =====
module vfcm_queue #(
	parameter int unsigned DEPTH = 4
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  vfcm_pkg::vfcm_push_t  push,
	input  logic                  pop,
	output vfcm_pkg::vfcm_job_t   head,
	output vfcm_pkg::vfcm_qstat_t qstat
);
	import vfcm_pkg::*;

	localparam int unsigned PW = $clog2(DEPTH);
	localparam int unsigned CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
	localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

	vfcm_job_t     slots_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          do_push;
	logic          do_pop;

	assign do_push = push.push && (count_q != CNT_FULL);
	assign do_pop  = pop && (count_q != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			slots_q[wr_ptr_q] <= push.job;
		end
	end

	assign head           = slots_q[rd_ptr_q];
	assign qstat.full     = (count_q == CNT_FULL);
	assign qstat.nonempty = (count_q != '0);

endmodule

// ===== design/vfcm_back.sv =====
module vfcm_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  vfcm_pkg::vfcm_job_t   head,
	input  vfcm_pkg::vfcm_qstat_t qstat,
	output logic                  pop,
	output logic                  strobe,
	output vfcm_pkg::vfcm_out_t   vertex
);
	import vfcm_pkg::*;

	logic       active_q;
	vfcm_job_t  job_q;
	logic [5:0] rem_q;
	logic [2:0] vtx_q;
	logic       strobe_q;
	vfcm_out_t  vertex_q;

	vfcm_face_t face;
	logic [4:0] dvec;
	logic       face_done;
	logic [5:0] rem_next;
	logic       run_done;
	logic [4:0] vx;
	logic [7:0] vy;
	logic [4:0] vz;
	vfcm_out_t  vert_next;

	always_comb begin
		face = '0;
		for (int i = FACES - 1; i >= 0; i--) begin
			if (rem_q[i]) begin
				face = vfcm_face_t'(i);
			end
		end
	end

	always_comb begin
		dvec      = FACE_VERTS[face][vtx_q];
		face_done = (vtx_q == LAST_VTX);
		rem_next  = rem_q & ~(6'b000001 << face);
		run_done  = face_done && (rem_next == 6'd0);

		vx = {1'b0, job_q.pos_x} + {4'd0, dvec[0]};
		vy = {1'b0, job_q.pos_y} + {7'd0, dvec[1]};
		vz = {1'b0, job_q.pos_z} + {4'd0, dvec[2]};

		vert_next.byte_pos    = {vy[2:0], 5'd0} | {3'd0, vx};
		vert_next.byte_corner = {3'd0, vy[7:3]} | {2'd0, dvec[4:3], 4'd0}
			| {FACE_CLASS[face], 6'd0};
		vert_next.byte_z      = vz;
		vert_next.byte_kind   = job_q.kind;
		vert_next.layer       = job_q.clear;
		vert_next.last        = run_done;
	end

	assign pop = qstat.nonempty && (!active_q || run_done);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			rem_q    <= '0;
			vtx_q    <= '0;
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= active_q;
			if (pop) begin
				active_q <= 1'b1;
				rem_q    <= head.faces;
				vtx_q    <= '0;
			end else if (active_q && run_done) begin
				active_q <= 1'b0;
			end else if (active_q) begin
				if (face_done) begin
					rem_q <= rem_next;
					vtx_q <= '0;
				end else begin
					vtx_q <= vtx_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			job_q <= head;
		end
		vertex_q <= vert_next;
	end

	assign strobe = strobe_q;
	assign vertex = vertex_q;

endmodule

// ===== design/voxel_face_cull_mesher.sv =====
// Channel   Handshake          Payload
// voxel     start / busy       vfcm_in_t  (one voxel with its neighbor flags)
// vertex    strobe             vfcm_out_t (one packed vertex)
//
// Each item is classified in the cycle it is accepted and queued if it is solid and
// shows any face. The vertex generator emits one vertex per cycle, six per visible
// face; an item with no visible face is not queued. When the generator is idle, an
// accepted item passes in turn the queue, the job register and the output register.
// Reset clears the queue and the generator. Busy is high only while the queue is full.
module voxel_face_cull_mesher #(
	parameter int unsigned QDEPTH = 4
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  vfcm_pkg::vfcm_in_t  voxel,
	output logic                busy,
	output logic                strobe,
	output vfcm_pkg::vfcm_out_t vertex
);
	import vfcm_pkg::*;

	vfcm_push_t  push;
	vfcm_qstat_t qstat;
	vfcm_job_t   head;
	logic        pop;

	vfcm_front u_front (
		.start (start),
		.voxel (voxel),
		.qstat (qstat),
		.busy  (busy),
		.push  (push)
	);

	vfcm_queue #(
		.DEPTH (QDEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.pop    (pop),
		.head   (head),
		.qstat  (qstat)
	);

	vfcm_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (head),
		.qstat  (qstat),
		.pop    (pop),
		.strobe (strobe),
		.vertex (vertex)
	);

	a_run_gapless: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !vertex.last |=> strobe)
		else $error("Vertex run broke before its last vertex.");

	a_run_layer: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !vertex.last |=> vertex.layer == $past(vertex.layer))
		else $error("Layer changed within one item's run.");

	a_pop_emits: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> ##1 strobe)
		else $error("Queue pop produced no vertex.");

	a_busy_queued: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> qstat.nonempty)
		else $error("Busy raised with an empty queue.");

endmodule

// ===== tb/voxel_face_cull_mesher_test.sv =====
`timescale 1ns / 1ps

module voxel_face_cull_mesher_test;
	import vfcm_pkg::*;

	localparam int unsigned RANDOM_ITEMS = 300;
	localparam int unsigned DIRECTED_ACTIVE = 20;
	localparam int unsigned STALL_LIMIT = 2000;
	localparam int unsigned TAIL_CYCLES = 40;

	// Corner offsets of each face's six vertices, {dz, dy, dx}.
	localparam bit [2:0] FACE_OFFSETS [6][6] = '{
		'{3'b000, 3'b100, 3'b010, 3'b010, 3'b100, 3'b110},
		'{3'b101, 3'b001, 3'b111, 3'b111, 3'b001, 3'b011},
		'{3'b001, 3'b000, 3'b011, 3'b011, 3'b000, 3'b010},
		'{3'b100, 3'b101, 3'b110, 3'b110, 3'b101, 3'b111},
		'{3'b101, 3'b100, 3'b001, 3'b001, 3'b100, 3'b000},
		'{3'b011, 3'b010, 3'b111, 3'b111, 3'b010, 3'b110}
	};
	localparam int unsigned CORNER_SEQ [6] = '{0, 1, 2, 2, 1, 3};
	localparam int unsigned FACE_CLASS_OF [6] = '{0, 0, 1, 1, 3, 2};

	class vertex_scoreboard;
		vfcm_out_t expected_vertices[$];
		int unsigned errors;
		int unsigned voxels_seen;
		int unsigned vertices_checked;
		int unsigned faces_by_dir [6];

		function void note_voxel(input vfcm_in_t v);
			bit [5:0] shown;
			vfcm_out_t vt;
			bit [2:0] offs;
			int unsigned vx, vy, vz, n, total;
			voxels_seen++;
			if (!v.solid_here) return;
			for (int f = 0; f < 6; f++) begin
				shown[f] = !v.near_active[f] || (v.near_clear[f] && !v.clear_here);
			end
			if (v.pos_y == 0) shown[FACE_NEG_Y] = 1'b1;
			if (v.pos_y >= TOP_Y) shown[FACE_POS_Y] = 1'b1;
			total = 6 * $countones(shown);
			n = 0;
			for (int f = 0; f < 6; f++) begin
				if (!shown[f]) continue;
				faces_by_dir[f]++;
				for (int k = 0; k < 6; k++) begin
					offs = FACE_OFFSETS[f][k];
					vx = v.pos_x + offs[0];
					vy = v.pos_y + offs[1];
					vz = v.pos_z + offs[2];
					vt.byte_pos = 8'(vx | (vy << 5));
					vt.byte_corner = 8'((vy >> 3) | (CORNER_SEQ[k] << 4) | (FACE_CLASS_OF[f] << 6));
					vt.byte_z = 5'(vz);
					vt.byte_kind = v.kind;
					vt.layer = v.clear_here;
					vt.last = (n == total - 1);
					n++;
					expected_vertices.push_back(vt);
				end
			end
		endfunction

		function void compare_field(input string name, input int unsigned want,
				input int unsigned got);
			if (want != got) begin
				errors++;
				$display("%0t: vertex field %s mismatch, expected %0h, actual %0h",
					$time, name, want, got);
			end
		endfunction

		function void check_vertex(input vfcm_out_t got);
			vfcm_out_t want;
			vertices_checked++;
			if (expected_vertices.size() == 0) begin
				errors++;
				$display("%0t: unexpected vertex, expected none, actual %h", $time, got);
				return;
			end
			want = expected_vertices.pop_front();
			compare_field("byte_pos", want.byte_pos, got.byte_pos);
			compare_field("byte_corner", want.byte_corner, got.byte_corner);
			compare_field("byte_z", want.byte_z, got.byte_z);
			compare_field("byte_kind", want.byte_kind, got.byte_kind);
			compare_field("layer", want.layer, got.layer);
			compare_field("last", want.last, got.last);
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic start;
	vfcm_in_t voxel;
	logic busy;
	logic strobe;
	vfcm_out_t vertex;

	vertex_scoreboard sb = new;
	int unsigned quiet_cycles = 0;

	voxel_face_cull_mesher dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.voxel(voxel),
		.busy(busy),
		.strobe(strobe),
		.vertex(vertex)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n && start && !busy) sb.note_voxel(voxel);
		if (arst_n && strobe) sb.check_vertex(vertex);
	end

	always @(posedge clk) begin
		if ((start && !busy) || strobe) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
		end
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("%0t: no progress for %0d cycles", $time, quiet_cycles);
			$display("TEST FAILED");
			$finish;
		end
	end

	function automatic vfcm_in_t make_voxel(input int unsigned x, input int unsigned y,
			input int unsigned z, input int unsigned kind, input bit solid, input bit clear,
			input bit [5:0] nact, input bit [5:0] nclr);
		vfcm_in_t v;
		v.pos_x = 4'(x);
		v.pos_y = 7'(y);
		v.pos_z = 4'(z);
		v.kind = 8'(kind);
		v.solid_here = solid;
		v.clear_here = clear;
		v.near_active = nact;
		v.near_clear = nclr;
		return v;
	endfunction

	function automatic vfcm_in_t random_voxel();
		vfcm_in_t v;
		int unsigned pick;
		v = vfcm_in_t'($bits(vfcm_in_t)'({$urandom, $urandom}));
		v.solid_here = ($urandom_range(0, 9) != 0);
		v.clear_here = ($urandom_range(0, 3) == 0);
		pick = $urandom_range(0, 9);
		if (pick == 0) v.pos_y = 7'd0;
		else if (pick == 1) v.pos_y = TOP_Y;
		else if (pick == 2) v.pos_y = TOP_Y - 7'd1;
		else if (pick == 3) v.pos_y = 7'd1;
		// Mostly buried voxels with a face or two exposed, as on a real surface.
		if ($urandom_range(0, 2) != 0) begin
			v.near_active = 6'h3F;
			for (int f = 0; f < 6; f++) begin
				if ($urandom_range(0, 7) == 0) v.near_active[f] = 1'b0;
			end
			v.near_clear = 6'($urandom) & 6'($urandom);
		end
		return v;
	endfunction

	task automatic send_voxel(input vfcm_in_t v);
		start <= 1'b1;
		voxel <= v;
		do @(posedge clk); while (busy);
		@(negedge clk);
	endtask

	task automatic idle_for(input int unsigned cycles);
		if (cycles == 0) return;
		start <= 1'b0;
		repeat (cycles) @(negedge clk);
	endtask

	task automatic random_gap();
		int unsigned r;
		r = $urandom_range(0, 19);
		if (r < 10) idle_for(0);
		else if (r < 18) idle_for($urandom_range(1, 3));
		else idle_for($urandom_range(10, 40));
	endtask

	task automatic wait_all_vertices();
		start <= 1'b0;
		@(negedge clk);
		while (sb.expected_vertices.size() != 0) @(negedge clk);
	endtask

	initial begin
		int unsigned active_sent;
		int unsigned sent;
		bit quiet_stretch;
		bit drained;
		vfcm_in_t v;
		arst_n = 1'b0;
		start = 1'b0;
		voxel = '0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// An inactive voxel must stay silent even with every other bit set.
		send_voxel(make_voxel(15, 127, 15, 255, 0, 1, 6'h3F, 6'h3F));
		send_voxel(make_voxel(0, 0, 0, 0, 0, 0, 6'h00, 6'h00));
		send_voxel(make_voxel(15, 127, 15, 255, 1, 0, 6'h00, 6'h00));
		send_voxel(make_voxel(15, 127, 15, 255, 1, 1, 6'h00, 6'h3F));
		send_voxel(make_voxel(0, 0, 0, 0, 1, 0, 6'h3F, 6'h00));
		send_voxel(make_voxel(7, 127, 9, 18, 1, 0, 6'h3F, 6'h00));
		send_voxel(make_voxel(7, 126, 9, 18, 1, 0, 6'h3F, 6'h00));
		send_voxel(make_voxel(3, 1, 12, 77, 1, 1, 6'h3F, 6'h3F));
		for (int f = 0; f < 6; f++) begin
			send_voxel(make_voxel(f * 2, 40 + f * 13, 15 - f, 8'hA0 + f, 1, 0,
				6'h3F & ~(6'h01 << f), 6'h00));
		end
		for (int f = 0; f < 6; f++) begin
			send_voxel(make_voxel(15 - f, 60 + f, f, 8'h50 + f, 1, bit'(f % 2),
				6'h3F, 6'h01 << f));
		end
		send_voxel(make_voxel(15, 31, 15, 1, 1, 0, 6'h3F, 6'h3F));
		send_voxel(make_voxel(15, 127, 0, 254, 1, 1, 6'h3F, 6'h00));
		idle_for(5);

		active_sent = 0;
		sent = 0;
		quiet_stretch = 0;
		drained = 0;
		while (sent < RANDOM_ITEMS) begin
			if (sent % 40 == 0) quiet_stretch = ($urandom_range(0, 2) == 0);
			v = random_voxel();
			send_voxel(v);
			sent++;
			if (v.solid_here) active_sent++;
			if (!drained && sent >= RANDOM_ITEMS / 2) begin
				wait_all_vertices();
				drained = 1;
			end else if (!quiet_stretch) begin
				random_gap();
			end
		end

		wait_all_vertices();
		repeat (TAIL_CYCLES) @(negedge clk);
		$display("Sent %0d voxels (%0d active); checked %0d vertices.",
			sb.voxels_seen, active_sent + DIRECTED_ACTIVE, sb.vertices_checked);
		$display("Faces shown per direction -x %0d +x %0d -z %0d +z %0d -y %0d +y %0d.",
			sb.faces_by_dir[0], sb.faces_by_dir[1], sb.faces_by_dir[2],
			sb.faces_by_dir[3], sb.faces_by_dir[4], sb.faces_by_dir[5]);
		if (sb.errors == 0 && sb.expected_vertices.size() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
